// ===== src/bqtrw_pkg.sv =====
`timescale 1ns / 1ps

package bqtrw_pkg;

    localparam int MAX_DIM_DEF   = 1024;
    localparam int ADDR_BITS_DEF = 20;

    localparam int DIM_W      = 11;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int OUT_ADDR_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIENT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd6;

    localparam logic [1:0]       RST_ORIENT    = 2'd0;
    localparam logic [DIM_W-1:0] RST_WIDTH     = 11'd160;
    localparam logic [DIM_W-1:0] RST_HEIGHT    = 11'd160;
    localparam logic [DIM_W-1:0] RST_ROW_BYTES = 11'd20;
    localparam logic [1:0]       RST_DEPTH     = 2'd0;

    localparam logic [1:0] ORIENT_UP  = 2'd0;
    localparam logic [1:0] ORIENT_90  = 2'd1;
    localparam logic [1:0] ORIENT_180 = 2'd2;
    localparam logic [1:0] ORIENT_270 = 2'd3;

    localparam logic [1:0] KIND_OR        = 2'd0;
    localparam logic [1:0] KIND_CLR_BYTE  = 2'd1;
    localparam logic [1:0] KIND_CLR_COL   = 2'd2;

    typedef struct packed {
        logic [1:0]            kind;
        logic [OUT_ADDR_W-1:0] address;
        logic [7:0]            mask;
        logic [DIM_W-1:0]      count;
        logic                  step_up;
        logic                  last;
    } t_result;

    function automatic logic [7:0] black_low(input logic [1:0] depth);
        logic [7:0] m;
        unique case (depth)
            2'd0:    m = 8'h01;
            2'd1:    m = 8'h03;
            2'd2:    m = 8'h0F;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] black_high(input logic [1:0] depth);
        logic [7:0] m;
        unique case (depth)
            2'd0:    m = 8'h80;
            2'd1:    m = 8'hC0;
            2'd2:    m = 8'hF0;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

endpackage

// ===== src/bqtrw_rem.sv =====
`timescale 1ns / 1ps

module bqtrw_rem #(
    parameter int DW = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DW-1:0]                 i_dividend,
    input  logic [bqtrw_pkg::DIM_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [bqtrw_pkg::DIM_W-1:0]   o_rem
);
    import bqtrw_pkg::*;

    localparam int CNTW = $clog2(DW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNTW-1:0]   r_cnt;
    logic [DW-1:0]     r_quo;
    logic [DIM_W-1:0]  r_rem;
    logic [DIM_W-1:0]  r_div;

    logic [DIM_W:0]    w_trial;
    logic              w_ge;
    logic [DIM_W-1:0]  w_next;

    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_next  = w_ge ? DIM_W'(w_trial - {1'b0, r_div}) : w_trial[DIM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DW);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_next;
                r_quo <= r_quo << 1;
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("remainder unit started while busy");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_div != '0) |-> (r_rem < r_div))
        else $error("remainder not below divisor");

endmodule

// ===== src/bqtrw_obuf.sv =====
`timescale 1ns / 1ps

module bqtrw_obuf (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  bqtrw_pkg::t_result               i_result,
    input  logic                             i_stall,
    output logic                             o_free,
    output logic                             o_valid,
    output logic [1:0]                       o_kind,
    output logic [bqtrw_pkg::OUT_ADDR_W-1:0] o_address,
    output logic [7:0]                       o_mask,
    output logic [bqtrw_pkg::DIM_W-1:0]      o_count,
    output logic                             o_step_up,
    output logic                             o_last
);
    import bqtrw_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_res   <= i_result;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid   = r_valid;
    assign o_kind    = r_res.kind;
    assign o_address = r_res.address;
    assign o_mask    = r_res.mask;
    assign o_count   = r_res.count;
    assign o_step_up = r_res.step_up;
    assign o_last    = r_res.last;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("output word overwritten while stalled");

endmodule

// ===== src/bitmap_quarter_turn_rotate_writer_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_stall  i_pixel
// out       output     o_out_valid / i_out_stall  o_kind o_address o_mask o_count
//                                                   o_step_up o_last
// cfg       input      i_cfg_we                 i_cfg_index i_cfg_data
//
// A pixel inside a row passes through S_PIX, then S_CLR as well when it makes an OR word
// and a byte-clear word. An upright or upside-down row start first passes S_GEOM (geometry),
// then S_MUL (the row multiply). A sideways row start passes S_GEOM, S_MUL, S_DIV and S_COL;
// S_DIV waits on the remainder unit, which works one bit of the TW-bit byte column a cycle.
// Reset is synchronous and active low; it restores the register defaults and counters.
// While the output word is stalled the sequencer waits before producing the next word.

module bitmap_quarter_turn_rotate_writer_core #(
    parameter int MAX_DIM   = bqtrw_pkg::MAX_DIM_DEF,
    parameter int ADDR_BITS = bqtrw_pkg::ADDR_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_pixel,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [1:0]                       o_kind,
    output logic [bqtrw_pkg::OUT_ADDR_W-1:0] o_address,
    output logic [7:0]                       o_mask,
    output logic [bqtrw_pkg::DIM_W-1:0]      o_count,
    output logic                             o_step_up,
    output logic                             o_last,
    input  logic                             i_cfg_we,
    input  logic [bqtrw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bqtrw_pkg::CFG_W-1:0]      i_cfg_data
);
    import bqtrw_pkg::*;

    localparam int IW = $clog2(MAX_DIM);
    localparam int GW = (IW > DIM_W) ? IW : DIM_W;
    localparam int TW = GW + 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_GEOM = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_COL  = 7'b0010000,
        S_PIX  = 7'b0100000,
        S_CLR  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]       r_orient;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [DIM_W-1:0] r_row_bytes;
    logic [1:0]       r_depth;
    logic [9:0]       r_ox;
    logic [9:0]       r_oy;

    logic [IW-1:0]        r_col_idx;
    logic [IW-1:0]        r_row_idx;
    logic [ADDR_BITS-1:0] r_addr;
    logic [7:0]           r_bmask;
    logic [DIM_W-1:0]     r_last_col;
    logic                 r_col_valid;
    logic                 r_pix_nz;
    logic [TW-1:0]        r_tx;
    logic [TW-1:0]        r_ty;

    logic                 w_accept;
    logic                 w_sideways;
    logic [DIM_W-1:0]     w_w;
    logic [DIM_W-1:0]     w_h;
    logic [3:0]           w_bpp;
    logic [7:0]           w_black;
    logic [7:0]           w_black_hi;

    logic [GW-1:0]        w_row_ext;
    logic [GW-1:0]        w_hm1;
    logic [GW-1:0]        w_wm1;
    logic [GW-1:0]        w_row;
    logic [GW-1:0]        w_hmr;
    logic [GW-1:0]        w_x;
    logic [GW-1:0]        w_y;

    logic [TW+2:0]        w_txs;
    logic [TW-1:0]        w_xbyte;
    logic [2:0]           w_pos;
    logic [TW+10:0]       w_prod;
    logic [TW+11:0]       w_sum;
    logic [ADDR_BITS+TW+11:0] w_sum_ext;
    logic [ADDR_BITS-1:0] w_new_addr;
    logic [7:0]           w_new_mask;

    logic [ADDR_BITS+DIM_W-1:0] w_rb_ext;
    logic [ADDR_BITS-1:0] w_rb_a;
    logic [7:0]           w_mask_r;
    logic [7:0]           w_mask_l;
    logic                 w_clr;
    logic [ADDR_BITS-1:0] w_upd_addr;
    logic [7:0]           w_upd_mask;
    logic [ADDR_BITS+OUT_ADDR_W-1:0] w_addr_ext;
    logic [ADDR_BITS+OUT_ADDR_W-1:0] w_upd_ext;
    logic [OUT_ADDR_W-1:0] w_addr_out;
    logic [OUT_ADDR_W-1:0] w_upd_out;

    logic                 w_rem_start;
    logic                 w_rem_done;
    logic [DIM_W-1:0]     w_rem;
    logic                 w_col_new;
    logic                 w_col_take;
    logic                 w_out_free;
    logic                 w_load;
    logic                 w_commit;
    t_result              w_res;

    logic [IW:0]          w_ci_inc;
    logic [IW:0]          w_ri_inc;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_sideways = r_orient[0];

    always_comb begin
        if (r_width == '0) begin
            w_w = DIM_W'(1);
        end else if (r_width > MAX_DIM) begin
            w_w = DIM_W'(MAX_DIM);
        end else begin
            w_w = r_width;
        end
        if (r_height == '0) begin
            w_h = DIM_W'(1);
        end else if (r_height > MAX_DIM) begin
            w_h = DIM_W'(MAX_DIM);
        end else begin
            w_h = r_height;
        end
    end

    assign w_bpp      = 4'd1 << r_depth;
    assign w_black    = black_low(r_depth);
    assign w_black_hi = black_high(r_depth);

    assign w_row_ext = GW'(r_row_idx);
    assign w_hm1     = GW'(w_h - DIM_W'(1));
    assign w_wm1     = GW'(w_w - DIM_W'(1));
    assign w_row     = (w_row_ext < GW'(w_h)) ? w_row_ext : w_hm1;
    assign w_hmr     = w_hm1 - w_row;

    always_comb begin
        unique case (r_orient)
            ORIENT_UP: begin
                w_x = '0;
                w_y = w_row;
            end
            ORIENT_90: begin
                w_x = w_hmr;
                w_y = '0;
            end
            ORIENT_180: begin
                w_x = w_wm1;
                w_y = w_hmr;
            end
            default: begin
                w_x = w_row;
                w_y = w_wm1;
            end
        endcase
    end

    assign w_txs      = {3'b000, r_tx} << r_depth;
    assign w_xbyte    = w_txs[TW+2:3];
    assign w_pos      = w_txs[2:0];
    assign w_prod     = (TW+11)'(r_ty) * (TW+11)'(r_row_bytes);
    assign w_sum      = {1'b0, w_prod} + (TW+12)'(w_xbyte);
    assign w_sum_ext  = {{ADDR_BITS{1'b0}}, w_sum};
    assign w_new_addr = w_sum_ext[ADDR_BITS-1:0];
    assign w_new_mask = w_black_hi >> w_pos;

    assign w_rb_ext = {{ADDR_BITS{1'b0}}, r_row_bytes};
    assign w_rb_a   = w_rb_ext[ADDR_BITS-1:0];
    assign w_mask_r = r_bmask >> w_bpp;
    assign w_mask_l = r_bmask << w_bpp;

    always_comb begin
        w_clr      = 1'b0;
        w_upd_addr = r_addr;
        w_upd_mask = r_bmask;
        unique case (r_orient)
            ORIENT_UP: begin
                if (w_mask_r == '0) begin
                    w_clr      = 1'b1;
                    w_upd_mask = w_black_hi;
                    w_upd_addr = r_addr + ADDR_BITS'(1);
                end else begin
                    w_upd_mask = w_mask_r;
                end
            end
            ORIENT_180: begin
                if (w_mask_l == '0) begin
                    w_clr      = 1'b1;
                    w_upd_mask = w_black;
                    w_upd_addr = r_addr - ADDR_BITS'(1);
                end else begin
                    w_upd_mask = w_mask_l;
                end
            end
            ORIENT_90: begin
                w_upd_addr = r_addr + w_rb_a;
            end
            default: begin
                w_upd_addr = r_addr - w_rb_a;
            end
        endcase
    end

    assign w_addr_ext = {{OUT_ADDR_W{1'b0}}, r_addr};
    assign w_upd_ext  = {{OUT_ADDR_W{1'b0}}, w_upd_addr};
    assign w_addr_out = w_addr_ext[OUT_ADDR_W-1:0];
    assign w_upd_out  = w_upd_ext[OUT_ADDR_W-1:0];

    assign w_col_new = !r_col_valid || (w_rem != r_last_col);

    always_comb begin
        n_state     = r_state;
        w_load      = 1'b0;
        w_commit    = 1'b0;
        w_col_take  = 1'b0;
        w_rem_start = 1'b0;
        w_res       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (r_col_idx == '0) ? S_GEOM : S_PIX;
                end
            end
            S_GEOM: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (w_sideways) begin
                    w_rem_start = 1'b1;
                    n_state     = S_DIV;
                end else begin
                    n_state = S_PIX;
                end
            end
            S_DIV: begin
                if (w_rem_done) begin
                    n_state = S_COL;
                end
            end
            S_COL: begin
                if (w_col_new) begin
                    w_res.kind    = KIND_CLR_COL;
                    w_res.address = w_addr_out;
                    w_res.count   = w_w;
                    w_res.step_up = (r_orient == ORIENT_270);
                    w_res.last    = !r_pix_nz;
                    if (w_out_free) begin
                        w_load     = 1'b1;
                        w_col_take = 1'b1;
                        n_state    = S_PIX;
                    end
                end else begin
                    n_state = S_PIX;
                end
            end
            S_PIX: begin
                if (r_pix_nz) begin
                    w_res.kind    = KIND_OR;
                    w_res.address = w_addr_out;
                    w_res.mask    = r_bmask;
                    w_res.last    = !w_clr;
                    if (w_out_free) begin
                        w_load = 1'b1;
                        if (w_clr) begin
                            n_state = S_CLR;
                        end else begin
                            w_commit = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                end else if (w_clr) begin
                    w_res.kind    = KIND_CLR_BYTE;
                    w_res.address = w_upd_out;
                    w_res.last    = 1'b1;
                    if (w_out_free) begin
                        w_load   = 1'b1;
                        w_commit = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    w_commit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_CLR: begin
                w_res.kind    = KIND_CLR_BYTE;
                w_res.address = w_upd_out;
                w_res.last    = 1'b1;
                if (w_out_free) begin
                    w_load   = 1'b1;
                    w_commit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_ci_inc = {1'b0, r_col_idx} + (IW+1)'(1);
    assign w_ri_inc = {1'b0, r_row_idx} + (IW+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_orient    <= RST_ORIENT;
            r_width     <= RST_WIDTH;
            r_height    <= RST_HEIGHT;
            r_row_bytes <= RST_ROW_BYTES;
            r_depth     <= RST_DEPTH;
            r_ox        <= '0;
            r_oy        <= '0;
            r_col_idx   <= '0;
            r_row_idx   <= '0;
            r_addr      <= '0;
            r_bmask     <= '0;
            r_last_col  <= '1;
            r_col_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ORIENT:    r_orient    <= i_cfg_data[1:0];
                    CFG_WIDTH:     r_width     <= i_cfg_data;
                    CFG_HEIGHT:    r_height    <= i_cfg_data;
                    CFG_ROW_BYTES: r_row_bytes <= i_cfg_data;
                    CFG_DEPTH:     r_depth     <= i_cfg_data[1:0];
                    CFG_ORIGIN_X:  r_ox        <= i_cfg_data[9:0];
                    CFG_ORIGIN_Y:  r_oy        <= i_cfg_data[9:0];
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_pix_nz <= |i_pixel;
            end
            if (r_state == S_GEOM) begin
                r_tx <= {1'b0, w_x} + TW'(r_ox);
                r_ty <= {1'b0, w_y} + TW'(r_oy);
            end
            if (r_state == S_MUL) begin
                r_addr  <= w_new_addr;
                r_bmask <= w_new_mask;
            end
            if (w_col_take) begin
                r_last_col  <= w_rem;
                r_col_valid <= 1'b1;
            end
            if (w_commit) begin
                r_addr  <= w_upd_addr;
                r_bmask <= w_upd_mask;
                if (w_ci_inc >= w_w) begin
                    r_col_idx <= '0;
                    if (w_ri_inc >= w_h) begin
                        r_row_idx   <= '0;
                        r_col_valid <= 1'b0;
                        r_last_col  <= '1;
                    end else begin
                        r_row_idx <= w_ri_inc[IW-1:0];
                    end
                end else begin
                    r_col_idx <= w_ci_inc[IW-1:0];
                end
            end
        end
    end

    bqtrw_rem #(
        .DW (TW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (w_xbyte),
        .i_divisor  (r_row_bytes),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    bqtrw_obuf u_obuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_load),
        .i_result  (w_res),
        .i_stall   (i_out_stall),
        .o_free    (w_out_free),
        .o_valid   (o_out_valid),
        .o_kind    (o_kind),
        .o_address (o_address),
        .o_mask    (o_mask),
        .o_count   (o_count),
        .o_step_up (o_step_up),
        .o_last    (o_last)
    );

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_GEOM || r_state == S_PIX))
        else $error("accepted word did not start processing");

    a_col_sideways: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_res.kind == KIND_CLR_COL) |-> w_sideways)
        else $error("column clear outside a sideways orientation");

    a_byte_upright: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_res.kind == KIND_CLR_BYTE) |-> !w_sideways)
        else $error("byte clear in a sideways orientation");

endmodule
